@@ design/esckd_pkg.sv @@
`default_nettype none
package esckd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_SS3   = 3'd3,
    PH_ONE   = 3'd4,
    PH_TRAIL = 3'd5,
    PH_SKIP2 = 3'd6,
    PH_SKIP1 = 3'd7
  } phase_t;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  localparam logic [9:0] K_UP        = 10'd1001;
  localparam logic [9:0] K_DOWN      = 10'd1002;
  localparam logic [9:0] K_LEFT      = 10'd1003;
  localparam logic [9:0] K_RIGHT     = 10'd1004;
  localparam logic [9:0] K_HOME      = 10'd1005;
  localparam logic [9:0] K_END       = 10'd1006;
  localparam logic [9:0] K_BACKSPACE = 10'd1007;
  localparam logic [9:0] K_DELETE    = 10'd1008;
  localparam logic [9:0] K_TAB       = 10'd1009;
  localparam logic [9:0] K_ENTER     = 10'd1010;
  localparam logic [9:0] K_ESCAPE    = 10'd1011;
  localparam logic [9:0] K_PAGE_UP   = 10'd1012;
  localparam logic [9:0] K_PAGE_DOWN = 10'd1013;
  localparam logic [9:0] K_F1        = 10'd1014;
  localparam logic [9:0] K_F2        = 10'd1015;
  localparam logic [9:0] K_F3        = 10'd1016;
  localparam logic [9:0] K_F4        = 10'd1017;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_O     = 8'h4F;  // 'O'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [9:0] key;
  } result_t;

endpackage
`default_nettype wire

@@ design/esckd_in_reg.sv @@
`default_nettype none
module esckd_in_reg
  import esckd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  consume,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

@@ design/esckd_parser.sv @@
`default_nettype none
module esckd_parser
  import esckd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t item,
  input  wire logic  advance,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [9:0] pending_r, pending_nxt;
  logic       is_byte;
  logic [7:0] b;

  assign is_byte = (item.action == ACT_BYTE);
  assign b       = item.rx_byte;

  // next phase and pending key
  always_comb begin
    phase_nxt   = PH_IDLE;
    pending_nxt = pending_r;
    unique case (phase_r)
      PH_ESC: begin
        if (is_byte && b == CH_LBRK) begin
          phase_nxt = PH_CSI;
        end else if (is_byte && b == CH_O) begin
          phase_nxt = PH_SS3;
        end
      end
      PH_CSI: begin
        if (is_byte) begin
          unique case (b)
            CH_1: begin pending_nxt = K_HOME;      phase_nxt = PH_ONE;   end
            CH_3: begin pending_nxt = K_DELETE;    phase_nxt = PH_TRAIL; end
            CH_4: begin pending_nxt = K_END;       phase_nxt = PH_TRAIL; end
            CH_5: begin pending_nxt = K_PAGE_UP;   phase_nxt = PH_TRAIL; end
            CH_6: begin pending_nxt = K_PAGE_DOWN; phase_nxt = PH_TRAIL; end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
      PH_ONE: begin
        if (is_byte && b == CH_SEMI) begin
          phase_nxt = PH_SKIP2;
        end
      end
      PH_SKIP2: phase_nxt = PH_SKIP1;
      PH_IDLE: begin
        if (is_byte && b == CH_ESC) begin
          phase_nxt = PH_ESC;
        end
      end
      PH_SS3, PH_TRAIL, PH_SKIP1: phase_nxt = PH_IDLE;
    endcase
  end

  // decoded key for this beat
  always_comb begin
    res.emit = 1'b0;
    res.key  = K_ESCAPE;
    unique case (phase_r)
      PH_ESC: begin
        res.emit = !(is_byte && (b == CH_LBRK || b == CH_O));
      end
      PH_CSI: begin
        res.emit = 1'b1;
        if (is_byte) begin
          unique case (b)
            CH_A: res.key = K_UP;
            CH_B: res.key = K_DOWN;
            CH_C: res.key = K_RIGHT;
            CH_D: res.key = K_LEFT;
            CH_H: res.key = K_HOME;
            CH_F: res.key = K_END;
            CH_1, CH_3, CH_4, CH_5, CH_6: res.emit = 1'b0;
            default: res.key = K_ESCAPE;
          endcase
        end
      end
      PH_SS3: begin
        res.emit = 1'b1;
        if (is_byte) begin
          unique case (b)
            CH_H: res.key = K_HOME;
            CH_F: res.key = K_END;
            CH_P: res.key = K_F1;
            CH_Q: res.key = K_F2;
            CH_R: res.key = K_F3;
            CH_S: res.key = K_F4;
            default: res.key = K_ESCAPE;
          endcase
        end
      end
      PH_ONE: begin
        // '~', stray byte or timeout all end as Home
        res.emit = !(is_byte && b == CH_SEMI);
        res.key  = K_HOME;
      end
      PH_SKIP2: res.emit = 1'b0;
      PH_TRAIL, PH_SKIP1: begin
        res.emit = 1'b1;
        res.key  = pending_r;
      end
      PH_IDLE: begin
        res.emit = is_byte && (b != CH_ESC);
        priority if (b == CH_TAB) begin
          res.key = K_TAB;
        end else if (b == CH_LF || b == CH_CR) begin
          res.key = K_ENTER;
        end else if (b == CH_BS || b == CH_DEL) begin
          res.key = K_BACKSPACE;
        end else begin
          res.key = {2'b00, b};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pending_r <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/escape_sequence_key_decoder.sv @@
// Terminal escape-sequence key decoder.
// A beat sits in the input register; its key is then registered into out_*.
// Throughput: one beat per cycle unless a key waits on a stalled output; in_ready
// stays high while the output register is empty or drained in the same cycle.
// Reset (rst_n low, synchronous): parse phase idle, pending key zero,
// input and output registers empty.
`default_nettype none
module escape_sequence_key_decoder
  import esckd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [9:0]      out_key_code
);

  item_t      in_item, item;
  logic       item_valid;
  logic       consume;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  logic [9:0] key_r;

  assign in_item.action  = in_action;
  assign in_item.rx_byte = in_rx_byte;

  // a beat that yields no key never waits on the output side
  assign consume = item_valid && (!res.emit || !out_valid_r || out_ready);

  esckd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  esckd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (consume),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res.emit) begin
      key_r <= res.key;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = key_r;

endmodule
`default_nettype wire

@@ design/esckd_checker.sv @@
`default_nettype none
module esckd_checker
  import esckd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [9:0] out_key_code
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_code))
    else $error("stalled output beat changed");

  // only raw bytes or the special key range come out
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_code < 10'd256) ||
                  (out_key_code >= K_UP && out_key_code <= K_F4))
    else $error("key code out of range");

  // remapped control bytes and ESC never pass through raw
  a_no_raw_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_code != {2'b00, CH_BS} && out_key_code != {2'b00, CH_TAB} &&
                  out_key_code != {2'b00, CH_LF} && out_key_code != {2'b00, CH_CR} &&
                  out_key_code != {2'b00, CH_ESC} && out_key_code != {2'b00, CH_DEL})
    else $error("raw control byte emitted");

  // an empty output register lets the input side take a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(rst_n) && !$past(in_valid && in_ready) |-> in_ready)
    else $error("input stalled with empty pipeline");

endmodule

bind escape_sequence_key_decoder esckd_checker u_esckd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_key_code (out_key_code)
);
`default_nettype wire

@@ bench/tb_escape_sequence_key_decoder.sv @@
`timescale 1ns / 1ps
module tb_escape_sequence_key_decoder
  import esckd_pkg::*;
();

  typedef enum logic [1:0] {
    CHK_PRED = 2'd0,
    CHK_NONE = 2'd1,
    CHK_KEY  = 2'd2
  } chk_t;

  typedef struct {
    logic       action;
    logic [7:0] rx_byte;
    chk_t       kind;
    logic [9:0] key;
  } term_beat_t;

  localparam int unsigned RANDOM_BEATS = 1600;
  localparam int unsigned TAIL_BEATS   = 150;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_action    = ACT_BYTE;
  logic [7:0] in_rx_byte   = 8'd0;
  logic       out_ready    = 1'b1;
  logic       in_ready;
  logic       out_valid;
  logic [9:0] out_key_code;

  chk_t       drv_kind = CHK_PRED;
  logic [9:0] drv_key  = 10'd0;
  logic       quiet    = 1'b0;
  logic       tail_run = 1'b0;

  term_beat_t  byte_q[$];
  logic [9:0]  key_q[$];
  int unsigned err_cnt    = 0;
  int unsigned stall_left = 0;

  // predictor state
  phase_t      dec_phase = PH_IDLE;
  logic [9:0]  dec_pend  = 10'd0;

  escape_sequence_key_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code)
  );

  always #4 clk = ~clk;

  function automatic void decode_key(input logic act, input logic [7:0] b,
                                     output logic hit, output logic [9:0] key);
    logic is_byte;
    is_byte = (act == ACT_BYTE);
    hit = 1'b1;
    key = K_ESCAPE;
    case (dec_phase)
      PH_ESC: begin
        if (is_byte && b == CH_LBRK) begin
          dec_phase = PH_CSI;
          hit = 1'b0;
        end else if (is_byte && b == CH_O) begin
          dec_phase = PH_SS3;
          hit = 1'b0;
        end
      end
      PH_CSI: begin
        if (is_byte) begin
          case (b)
            CH_A: key = K_UP;
            CH_B: key = K_DOWN;
            CH_C: key = K_RIGHT;
            CH_D: key = K_LEFT;
            CH_H: key = K_HOME;
            CH_F: key = K_END;
            CH_1: begin dec_pend = K_HOME;      dec_phase = PH_ONE;   hit = 1'b0; end
            CH_3: begin dec_pend = K_DELETE;    dec_phase = PH_TRAIL; hit = 1'b0; end
            CH_4: begin dec_pend = K_END;       dec_phase = PH_TRAIL; hit = 1'b0; end
            CH_5: begin dec_pend = K_PAGE_UP;   dec_phase = PH_TRAIL; hit = 1'b0; end
            CH_6: begin dec_pend = K_PAGE_DOWN; dec_phase = PH_TRAIL; hit = 1'b0; end
            default: key = K_ESCAPE;
          endcase
        end
      end
      PH_SS3: begin
        if (is_byte) begin
          case (b)
            CH_H: key = K_HOME;
            CH_F: key = K_END;
            CH_P: key = K_F1;
            CH_Q: key = K_F2;
            CH_R: key = K_F3;
            CH_S: key = K_F4;
            default: key = K_ESCAPE;
          endcase
        end
      end
      PH_ONE: begin
        if (is_byte && b == CH_SEMI) begin
          dec_phase = PH_SKIP2;
          hit = 1'b0;
        end else begin
          key = K_HOME;
        end
      end
      PH_SKIP2: begin
        dec_phase = PH_SKIP1;
        hit = 1'b0;
      end
      PH_TRAIL, PH_SKIP1: key = dec_pend;
      default: begin
        if (!is_byte) begin
          hit = 1'b0;
        end else if (b == CH_ESC) begin
          dec_phase = PH_ESC;
          hit = 1'b0;
        end else if (b == CH_TAB) begin
          key = K_TAB;
        end else if (b == CH_LF || b == CH_CR) begin
          key = K_ENTER;
        end else if (b == CH_BS || b == CH_DEL) begin
          key = K_BACKSPACE;
        end else begin
          key = {2'b00, b};
        end
      end
    endcase
    if (hit) dec_phase = PH_IDLE;
  endfunction

  task automatic add_row(input logic act, input logic [7:0] b, input chk_t kind,
                         input logic [9:0] key);
    term_beat_t t;
    t.action  = act;
    t.rx_byte = b;
    t.kind    = kind;
    t.key     = key;
    byte_q.push_back(t);
  endtask

  // random byte, or a timeout carrying a random byte
  task automatic add_tail();
    logic act;
    act = ($urandom_range(0, 3) == 0) ? ACT_TIMEOUT : ACT_BYTE;
    add_row(act, 8'($urandom), CHK_PRED, 10'd0);
  endtask

  task automatic gen_random_seq();
    int unsigned sel;
    logic [7:0]  c;
    sel = $urandom_range(0, 15);
    if (sel <= 3) begin
      add_row(ACT_BYTE, 8'($urandom_range(0, 255)), CHK_PRED, 10'd0);
    end else if (sel == 4) begin
      case ($urandom_range(0, 4))
        0: c = CH_BS;
        1: c = CH_TAB;
        2: c = CH_LF;
        3: c = CH_CR;
        default: c = CH_DEL;
      endcase
      add_row(ACT_BYTE, c, CHK_PRED, 10'd0);
    end else if (sel == 5) begin
      add_row(ACT_TIMEOUT, 8'($urandom), CHK_PRED, 10'd0);
    end else begin
      add_row(ACT_BYTE, CH_ESC, CHK_PRED, 10'd0);
      case (sel)
        6, 7: begin
          case ($urandom_range(0, 5))
            0: c = CH_A;
            1: c = CH_B;
            2: c = CH_C;
            3: c = CH_D;
            4: c = CH_H;
            default: c = CH_F;
          endcase
          add_row(ACT_BYTE, CH_LBRK, CHK_PRED, 10'd0);
          add_row(ACT_BYTE, c, CHK_PRED, 10'd0);
        end
        8: begin
          add_row(ACT_BYTE, CH_LBRK, CHK_PRED, 10'd0);
          add_row(ACT_BYTE, CH_3 + 8'($urandom_range(0, 3)), CHK_PRED, 10'd0);
          if ($urandom_range(0, 1) == 0) add_row(ACT_BYTE, CH_TILDE, CHK_PRED, 10'd0);
          else add_tail();
        end
        9: begin
          add_row(ACT_BYTE, CH_LBRK, CHK_PRED, 10'd0);
          add_row(ACT_BYTE, CH_1, CHK_PRED, 10'd0);
          case ($urandom_range(0, 2))
            0: add_row(ACT_BYTE, CH_TILDE, CHK_PRED, 10'd0);
            1: begin
              add_row(ACT_BYTE, CH_SEMI, CHK_PRED, 10'd0);
              add_tail();
              add_tail();
            end
            default: add_tail();
          endcase
        end
        10, 11: begin
          case ($urandom_range(0, 5))
            0: c = CH_H;
            1: c = CH_F;
            2: c = CH_P;
            3: c = CH_Q;
            4: c = CH_R;
            default: c = CH_S;
          endcase
          add_row(ACT_BYTE, CH_O, CHK_PRED, 10'd0);
          add_row(ACT_BYTE, c, CHK_PRED, 10'd0);
        end
        12: add_tail();
        13: begin
          add_row(ACT_BYTE, CH_LBRK, CHK_PRED, 10'd0);
          add_tail();
        end
        14: begin
          add_row(ACT_BYTE, CH_O, CHK_PRED, 10'd0);
          add_tail();
        end
        default: begin
          // cut short: the next sequence supplies the last skipped byte
          add_row(ACT_BYTE, CH_LBRK, CHK_PRED, 10'd0);
          add_row(ACT_BYTE, CH_1, CHK_PRED, 10'd0);
          add_row(ACT_BYTE, CH_SEMI, CHK_PRED, 10'd0);
          add_tail();
        end
      endcase
    end
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n || tail_run || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : mon
    logic       hit;
    logic [9:0] key;
    logic [9:0] want;
    if (rst_n) begin
      // check first: the key of a beat accepted now passes the input and output registers
      if (out_valid && out_ready) begin
        if (key_q.size() == 0) begin
          if (err_cnt < 10) $display("unexpected key %0d", out_key_code);
          err_cnt++;
        end else begin
          want = key_q.pop_front();
          if (out_key_code !== want) begin
            if (err_cnt < 10)
              $display("key mismatch: expected %0d, got %0d", want, out_key_code);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_key(in_action, in_rx_byte, hit, key);
        case (drv_kind)
          CHK_PRED: if (hit) key_q.push_back(key);
          CHK_KEY:  key_q.push_back(drv_key);
          default: ;
        endcase
      end
    end
  end

  initial begin
    term_beat_t t;
    int unsigned total;
    // directed: pass-through extremes, control bytes, a lone ESC and escape sequences from reset
    add_row(ACT_BYTE,    8'd0,     CHK_KEY,  10'd0);
    add_row(ACT_BYTE,    8'd255,   CHK_KEY,  10'd255);
    add_row(ACT_BYTE,    CH_TAB,   CHK_KEY,  K_TAB);
    add_row(ACT_BYTE,    CH_LF,    CHK_KEY,  K_ENTER);
    add_row(ACT_BYTE,    CH_CR,    CHK_KEY,  K_ENTER);
    add_row(ACT_BYTE,    CH_BS,    CHK_KEY,  K_BACKSPACE);
    add_row(ACT_BYTE,    CH_DEL,   CHK_KEY,  K_BACKSPACE);
    add_row(ACT_TIMEOUT, 8'hFF,    CHK_NONE, 10'd0);
    add_row(ACT_BYTE,    CH_ESC,   CHK_NONE, 10'd0);
    add_row(ACT_TIMEOUT, 8'd0,     CHK_KEY,  K_ESCAPE);
    add_row(ACT_BYTE,    CH_ESC,   CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_LBRK,  CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_A,     CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_ESC,   CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_LBRK,  CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_1,     CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_SEMI,  CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_5,     CHK_PRED, 10'd0);
    add_row(ACT_TIMEOUT, 8'd0,     CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_ESC,   CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_LBRK,  CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_3,     CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_TILDE, CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_ESC,   CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_O,     CHK_PRED, 10'd0);
    add_row(ACT_BYTE,    CH_S,     CHK_PRED, 10'd0);
    total = byte_q.size() + RANDOM_BEATS;
    while (byte_q.size() < total) gen_random_seq();
    total = byte_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < total; i++) begin
      t = byte_q[i];
      if (i % 64 == 0) quiet <= ($urandom_range(0, 3) == 0);
      if (i + TAIL_BEATS >= total) tail_run <= 1'b1;
      if (!quiet && !tail_run && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_action  <= t.action;
      in_rx_byte <= t.rx_byte;
      drv_kind   <= t.kind;
      drv_key    <= t.key;
      // hold the beat until it is taken
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (key_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && key_q.size() == 0) begin
      $display("escape_sequence_key_decoder verification clean");
    end else begin
      $display("escape_sequence_key_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("escape_sequence_key_decoder verification failed");
    $finish;
  end

endmodule

@@ files.f @@
design/esckd_pkg.sv
design/esckd_in_reg.sv
design/esckd_parser.sv
design/escape_sequence_key_decoder.sv
design/esckd_checker.sv
bench/tb_escape_sequence_key_decoder.sv
